[rtl/core/e2q_pkg.sv]
package e2q_pkg;
  localparam int AngleBits = 16;
  localparam int FracBits = 14;
  localparam int CordicStages = 14;
  localparam int WorkFrac = 30;
  localparam int OutW = 16;
  // residual angle at 2^40 per turn, signed
  localparam int ZW = 42;
  // cordic x/y with 30 fraction bits plus headroom
  localparam int XW = 33;
  localparam logic signed [XW-1:0] GainInit = 33'sd652032874;

  typedef logic signed [XW-1:0] cs_t;

  function automatic logic signed [ZW-1:0] atan_lut(input int i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0: v = 42'sd536870912;  1: v = 42'sd316933406;  2: v = 42'sd167458907;
      3: v = 42'sd85004756;   4: v = 42'sd42667331;   5: v = 42'sd21354465;
      6: v = 42'sd10679838;   7: v = 42'sd5340245;    8: v = 42'sd2670163;
      9: v = 42'sd1335087;   10: v = 42'sd667544;    11: v = 42'sd333772;
      12: v = 42'sd166886;   13: v = 42'sd83443;     14: v = 42'sd41722;
      15: v = 42'sd20861;    16: v = 42'sd10430;     17: v = 42'sd5215;
      18: v = 42'sd2608;     19: v = 42'sd1304;      20: v = 42'sd652;
      21: v = 42'sd326;      22: v = 42'sd163;       23: v = 42'sd81;
      24: v = 42'sd41;       25: v = 42'sd20;        26: v = 42'sd10;
      27: v = 42'sd5;        28: v = 42'sd3;         default: v = 42'sd1;
    endcase
    return v <<< 8;
  endfunction
endpackage

[rtl/core/euler_to_quaternion.sv]
// throughput: one set of angles per cycle, busy_o is always low
// the delay from start_i to done_o is set by the cordic stage chain, two multiply levels, a sum and a rounding stage
// the receiver cannot stall: each result shows for one cycle with done_o
// reset clears only the valid pipeline, data registers are not reset
module euler_to_quaternion (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  logic signed [15:0] angle_about_x_i,
  input  logic signed [15:0] angle_about_y_i,
  input  logic signed [15:0] angle_about_z_i,
  output logic done_o,
  output logic signed [15:0] quat_w_o,
  output logic signed [15:0] quat_x_o,
  output logic signed [15:0] quat_y_o,
  output logic signed [15:0] quat_z_o
);
  import e2q_pkg::*;

  localparam int Lat = CordicStages + 5;
  localparam int PW = 2 * XW;

  cs_t cx, sx, cy, sy, cz, sz;

  e2q_cordic u_cx (.clk_i, .angle_i(angle_about_x_i[AngleBits-1:0]), .cos_o(cx), .sin_o(sx));
  e2q_cordic u_cy (.clk_i, .angle_i(angle_about_y_i[AngleBits-1:0]), .cos_o(cy), .sin_o(sy));
  e2q_cordic u_cz (.clk_i, .angle_i(angle_about_z_i[AngleBits-1:0]), .cos_o(cz), .sin_o(sz));

  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i};
    end
  end
  assign busy_o = 1'b0;
  assign done_o = vld_q[Lat-1];

  function automatic cs_t mulq(cs_t a, cs_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    return XW'(p >>> WorkFrac);
  endfunction

  // first level pair products, z terms delayed alongside
  cs_t cycx_q, sysx_q, cysx_q, sycx_q, cz_q, sz_q;
  always_ff @(posedge clk_i) begin
    cycx_q <= mulq(cy, cx);
    sysx_q <= mulq(sy, sx);
    cysx_q <= mulq(cy, sx);
    sycx_q <= mulq(sy, cx);
    cz_q   <= cz;
    sz_q   <= sz;
  end

  cs_t t_q [8];
  always_ff @(posedge clk_i) begin
    t_q[0] <= mulq(cycx_q, cz_q);
    t_q[1] <= mulq(sysx_q, sz_q);
    t_q[2] <= mulq(cysx_q, cz_q);
    t_q[3] <= mulq(sycx_q, sz_q);
    t_q[4] <= mulq(sycx_q, cz_q);
    t_q[5] <= mulq(cysx_q, sz_q);
    t_q[6] <= mulq(cycx_q, sz_q);
    t_q[7] <= mulq(sysx_q, cz_q);
  end

  logic signed [XW:0] s_q [4];
  always_ff @(posedge clk_i) begin
    s_q[0] <= (XW+1)'(t_q[0]) + (XW+1)'(t_q[1]);
    s_q[1] <= (XW+1)'(t_q[2]) + (XW+1)'(t_q[3]);
    s_q[2] <= (XW+1)'(t_q[4]) - (XW+1)'(t_q[5]);
    s_q[3] <= (XW+1)'(t_q[6]) - (XW+1)'(t_q[7]);
  end

  localparam int Sh = WorkFrac - FracBits;
  localparam logic signed [XW:0] Lim = (XW+1)'(1) <<< FracBits;

  function automatic logic signed [OutW-1:0] finish(logic signed [XW:0] v);
    logic signed [XW+1:0] r;
    r = ((XW+2)'(v) + ((XW+2)'(1) <<< (Sh - 1))) >>> Sh;
    if (r > (XW+2)'(Lim)) r = (XW+2)'(Lim);
    if (r < -(XW+2)'(Lim)) r = -(XW+2)'(Lim);
    return OutW'(r);
  endfunction

  logic signed [OutW-1:0] q_q [4];
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) q_q[k] <= finish(s_q[k]);
  end

  assign quat_w_o = q_q[0];
  assign quat_x_o = q_q[1];
  assign quat_y_o = q_q[2];
  assign quat_z_o = q_q[3];
endmodule

[rtl/core/e2q_cordic.sv]
module e2q_cordic (
  input  logic clk_i,
  input  logic [e2q_pkg::AngleBits-1:0] angle_i,
  output e2q_pkg::cs_t cos_o,
  output e2q_pkg::cs_t sin_o
);
  import e2q_pkg::*;

  localparam int N = CordicStages;

  logic signed [ZW-1:0] z_q [N+1];
  cs_t x_q [N+1];
  cs_t y_q [N+1];

  always_ff @(posedge clk_i) begin
    // half angle: input times 2^(39-AngleBits)
    z_q[0] <= ZW'($signed(angle_i)) <<< (39 - AngleBits);
    x_q[0] <= GainInit;
    y_q[0] <= '0;
    for (int i = 0; i < N; i++) begin
      if (!z_q[i][ZW-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - atan_lut(i);
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + atan_lut(i);
      end
    end
  end

  assign cos_o = x_q[N];
  assign sin_o = y_q[N];
endmodule
